// File: design/assert_macros.svh
// Assertion helpers for the design files; only the top-level search module includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define CHECK_IMPLIES(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define CHECK_NEXT(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

// File: design/mbps_pkg.sv
`timescale 1ns / 1ps

package mbps_pkg;

  localparam int MAX_PATTERN_BYTES = 32;
  localparam int OFFSET_BITS       = 32;
  localparam int MATCH_OFFSET_W    = 32;
  localparam int BYTE_W            = 8;
  localparam int PAT_WORD_W        = 64;
  localparam int PAT_WORDS         = 4;
  localparam int PAT_IDX_W         = $clog2(MAX_PATTERN_BYTES);
  localparam int LEN_W             = 6;
  localparam int CARE_W            = 32;
  localparam int CFG_INDEX_W       = 3;
  localparam int CFG_DATA_W        = 64;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD_0 = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD_1 = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD_2 = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD_3 = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_CARE_MASK      = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 3'd5;

  typedef logic [BYTE_W-1:0]          byte_t;
  typedef logic [OFFSET_BITS-1:0]     cnt_t;
  typedef logic [LEN_W-1:0]           len_t;
  typedef logic [MATCH_OFFSET_W-1:0]  offset_t;
  typedef logic [CFG_INDEX_W-1:0]     cfg_index_t;
  typedef logic [CFG_DATA_W-1:0]      cfg_data_t;
  typedef logic [MAX_PATTERN_BYTES-1:0][BYTE_W-1:0] win_t;

  // Pattern laid out by window age: entry a is compared with the byte of age a
  typedef struct packed {
    len_t                        len;
    logic [MAX_PATTERN_BYTES-1:0] care;
    win_t                        bytes;
  } aligned_t;

endpackage

// File: design/mbps_scan_if.sv
`timescale 1ns / 1ps

interface mbps_scan_if;
  import mbps_pkg::*;

  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  region_end;

  modport source (output valid, data_byte, region_end, input ready);
  modport sink (input valid, data_byte, region_end, output ready);
endinterface

// File: design/mbps_result_if.sv
`timescale 1ns / 1ps

interface mbps_result_if;
  import mbps_pkg::*;

  logic    valid;
  logic    ready;
  logic    found;
  offset_t match_offset;

  modport source (output valid, found, match_offset, input ready);
  modport sink (input valid, found, match_offset, output ready);
endinterface

// File: design/masked_byte_pattern_search.sv
`timescale 1ns / 1ps
// Channel | Dir | Fields                    | Handshake
// scan    | in  | data_byte, region_end     | valid/ready, taken when both high
// result  | out | found, match_offset       | valid/ready, taken when both high
// cfg     | in  | cfg_index, cfg_data       | written when cfg_we is high
//
// One byte is taken every cycle unless a stalled result holds scan. A byte is registered in
// the window stage and its result, if any, in the result register. The rate is set by the
// parallel window compare between the window register and the result register. Reset is
// synchronous and active high. The aligned pattern is registered from the configuration
// registers. A stalled result register holds the window stage, which then holds scan.

module masked_byte_pattern_search (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  mbps_pkg::cfg_index_t cfg_index,
  input  mbps_pkg::cfg_data_t  cfg_data,
  mbps_scan_if.sink            scan,
  mbps_result_if.source        result
);
  import mbps_pkg::*;

  `include "assert_macros.svh"

  aligned_t                     aligned;
  win_t                         win;
  cnt_t                         count;
  cnt_t                         count_next;
  logic                         s1_valid;
  logic                         s1_last;
  logic                         reported;
  logic                         out_valid;
  logic                         found;
  offset_t                      match_offset;
  logic                         accept;
  logic                         adv;
  logic                         fire;
  logic                         match;
  logic                         hit;
  logic                         miss;
  logic [MAX_PATTERN_BYTES-1:0] pos_ok;

  mbps_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .aligned   (aligned)
  );

  assign adv        = !out_valid || result.ready;
  assign scan.ready = !s1_valid || adv;
  assign accept     = scan.valid && scan.ready;
  assign fire       = s1_valid && adv;

  // Restart the count after a region end; saturate at the top
  always_comb begin
    priority if (s1_last) begin
      count_next = cnt_t'(1);
    end else if (count == '1) begin
      count_next = count;
    end else begin
      count_next = count + cnt_t'(1);
    end
  end

  // Window stage: shift in the new byte
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_last  <= 1'b0;
      count    <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
        s1_last  <= scan.region_end;
        count    <= count_next;
      end else if (adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      win <= {win[MAX_PATTERN_BYTES-2:0], scan.data_byte};
    end
  end

  // Compare every window position against the aligned pattern
  always_comb begin
    for (int a = 0; a < MAX_PATTERN_BYTES; a++) begin
      pos_ok[a] = !aligned.care[a] || (win[a] == aligned.bytes[a]);
    end
  end

  assign match = &pos_ok;
  assign hit   = !reported && (count >= cnt_t'(aligned.len)) && match;
  assign miss  = s1_last && !reported && !hit;

  // Track whether this region has already reported a match
  always_ff @(posedge clk) begin
    if (rst) begin
      reported <= 1'b0;
    end else if (fire) begin
      if (s1_last) begin
        reported <= 1'b0;
      end else if (hit) begin
        reported <= 1'b1;
      end
    end
  end

  // Result register: load when free or drained, drop bytes with no result
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= fire && (hit || miss);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      found        <= hit;
      match_offset <= hit ? offset_t'(count - cnt_t'(aligned.len)) : '0;
    end
  end

  assign result.valid        = out_valid;
  assign result.found        = found;
  assign result.match_offset = match_offset;

  `CHECK_IMPLIES(a_count_live, clk, rst, s1_valid, count != '0, "window stage holds zero count")
  `CHECK_NEXT(a_hit_marks, clk, rst, fire && hit && !s1_last, reported, "match not recorded")
  `CHECK_NEXT(a_end_clears, clk, rst, fire && s1_last, !reported, "region end left report flag")

endmodule

// File: design/mbps_cfg.sv
`timescale 1ns / 1ps

module mbps_cfg (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  mbps_pkg::cfg_index_t cfg_index,
  input  mbps_pkg::cfg_data_t cfg_data,
  output mbps_pkg::aligned_t  aligned
);
  import mbps_pkg::*;

  logic [PAT_WORDS-1:0][PAT_WORD_W-1:0] pattern_words;
  logic [CARE_W-1:0]                    care_mask;
  len_t                                 pattern_length;
  win_t                                 pat_bytes;
  len_t                                 len_used;
  aligned_t                             aligned_next;

  // Hold the configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_words  <= '0;
      care_mask      <= '0;
      pattern_length <= len_t'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PATTERN_WORD_0,
        REG_PATTERN_WORD_1,
        REG_PATTERN_WORD_2,
        REG_PATTERN_WORD_3: pattern_words[cfg_index[1:0]] <= cfg_data;
        REG_CARE_MASK:      care_mask <= cfg_data[CARE_W-1:0];
        REG_PATTERN_LENGTH: pattern_length <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign pat_bytes = pattern_words;

  // Clamp the length to 1..MAX_PATTERN_BYTES
  always_comb begin
    priority if (pattern_length == '0) begin
      len_used = len_t'(1);
    end else if (pattern_length > len_t'(MAX_PATTERN_BYTES)) begin
      len_used = len_t'(MAX_PATTERN_BYTES);
    end else begin
      len_used = pattern_length;
    end
  end

  // Reverse the used pattern so byte j lines up with window age len-1-j
  always_comb begin
    len_t j;
    aligned_next.len = len_used;
    for (int a = 0; a < MAX_PATTERN_BYTES; a++) begin
      j = len_used - len_t'(a) - len_t'(1);
      aligned_next.bytes[a] = pat_bytes[j[PAT_IDX_W-1:0]];
      aligned_next.care[a]  = (len_t'(a) < len_used) & care_mask[j[PAT_IDX_W-1:0]];
    end
  end

  // Register the aligned view; a write reaches it through the configuration registers
  always_ff @(posedge clk) begin
    aligned <= aligned_next;
  end

endmodule
